// ===== design/sbrt_pkg.sv =====
// Package for the split bus request table: request and result payload
// types, controller command type and default sizes. No dependencies.
package sbrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 8;
  localparam int unsigned NUM_CORES_DEF   = 4;

  localparam int unsigned CORE_W = 2;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ADDR_W = 48;

  // Command code of an incoming request.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CORE_W-1:0] core;
    logic [KIND_W-1:0] req_kind;
    logic [ADDR_W-1:0] addr;
  } in_t;

  typedef struct packed {
    logic              nack;
    logic              done_valid;
    logic [CORE_W-1:0] done_core;
    logic [KIND_W-1:0] done_kind;
    logic [ADDR_W-1:0] done_addr;
  } out_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic step;
  } ctl_cmd_t;

endpackage

// ===== design/sbrt_ctrl.sv =====
// Controller of the split bus request table: tracks whether the result
// register is occupied and issues the step command. Uses sbrt_pkg.
module sbrt_ctrl
  import sbrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HELD  = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // The result register may be refilled in the cycle it drains.
  assign in_stall  = (state_r == ST_HELD) && out_stall;
  assign out_valid = (state_r == ST_HELD);
  assign cmd.step  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (cmd.step) state_nxt = ST_HELD;
      end
      ST_HELD: begin
        if (cmd.step)        state_nxt = ST_HELD;
        else if (!out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/sbrt_dp.sv =====
// Datapath of the split bus request table: slot storage, free-slot search,
// aging scan and result register. Uses sbrt_pkg.
module sbrt_dp
  import sbrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned NUM_CORES   = NUM_CORES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ctl_cmd_t cmd,
  input  in_t      req,
  output out_t     res
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned AGE_W = $clog2(NUM_CORES + 1);
  localparam logic [AGE_W-1:0] AGE_LIMIT = AGE_W'(NUM_CORES);

  logic [TABLE_DEPTH-1:0] busy_r;
  logic [TABLE_DEPTH-1:0] busy_nxt;
  logic [AGE_W-1:0]       age_r   [TABLE_DEPTH];
  logic [AGE_W-1:0]       age_nxt [TABLE_DEPTH];
  logic [CORE_W-1:0]      core_r  [TABLE_DEPTH];
  logic [KIND_W-1:0]      kind_r  [TABLE_DEPTH];
  logic [ADDR_W-1:0]      addr_r  [TABLE_DEPTH];
  out_t                   res_r;
  out_t                   res_nxt;

  logic             full;
  logic             ins;
  logic             upd;
  logic [IDX_W-1:0] free_idx;
  logic             done_hit;
  logic [IDX_W-1:0] done_idx;

  assign full = &busy_r;
  assign ins  = (req.cmd == CMD_SEND) && !full;
  // A refused send leaves the table untouched.
  assign upd  = cmd.step && !((req.cmd == CMD_SEND) && full);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!busy_r[i]) free_idx = IDX_W'(i);
    end
  end

  // Insert, then scan upward: age busy slots until the first one at the
  // limit, which is freed and reported. A fresh slot starts at age zero.
  always_comb begin
    logic             stop;
    logic             is_new;
    logic             b;
    logic [AGE_W-1:0] a;
    stop     = 1'b0;
    done_hit = 1'b0;
    done_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      is_new = ins && (free_idx == IDX_W'(i));
      b      = busy_r[i] || is_new;
      a      = is_new ? '0 : age_r[i];
      busy_nxt[i] = b;
      age_nxt[i]  = a;
      if (b && !stop) begin
        if (a < AGE_LIMIT) begin
          age_nxt[i] = a + AGE_W'(1);
        end else begin
          busy_nxt[i] = 1'b0;
          stop        = 1'b1;
          done_hit    = 1'b1;
          done_idx    = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    if ((req.cmd == CMD_SEND) && full) begin
      res_nxt.nack = 1'b1;
    end else if (done_hit) begin
      res_nxt.done_valid = 1'b1;
      res_nxt.done_core  = core_r[done_idx];
      res_nxt.done_kind  = kind_r[done_idx];
      res_nxt.done_addr  = addr_r[done_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) age_r[i] <= '0;
    end else if (upd) begin
      busy_r <= busy_nxt;
      for (int i = 0; i < TABLE_DEPTH; i++) age_r[i] <= age_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && ins) begin
      core_r[free_idx] <= req.core;
      kind_r[free_idx] <= req.req_kind;
      addr_r[free_idx] <= req.addr;
    end
    if (cmd.step) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== design/split_bus_request_table.sv =====
// Split bus request table. A request's result is registered and shows on
// out_data in the cycle after the request is accepted.
// Throughput: one request per cycle; the whole free-slot search and aging
// scan over the slot flops completes in that cycle, so only a held result
// under out_stall slows input. Reset (rst_n low, synchronous) frees every
// slot, clears all ages and marks the result register empty.
module split_bus_request_table
  import sbrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned NUM_CORES   = NUM_CORES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // The controller owns the handshake: it knows whether the result register
  // still holds an untaken request result and, if not (or if it drains this
  // cycle), tells the datapath to execute the incoming request.
  ctl_cmd_t cmd;

  sbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the slot table. Each step it inserts a send into the
  // lowest free slot (or refuses it, leaving the table as is, if all are
  // busy), ages busy slots upward to the first at the limit and retires it.
  sbrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_CORES   (NUM_CORES)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (in_data),
    .res   (out_data)
  );

endmodule
